@@ rtl/random_twinkle_fade_engine_assert.svh @@
// Assertion macros shared by the random twinkle fade engine RTL.
// Needs nothing but a clock and a reset signal in the using module.
`ifndef RANDOM_TWINKLE_FADE_ENGINE_ASSERT_SVH
`define RANDOM_TWINKLE_FADE_ENGINE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define RTFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold on the next clock.
`define RTFE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rtfe_pkg.sv @@
// Types, constants and helper functions of the random twinkle fade engine.
// Used by the channel interfaces and by every RTL module of the block but rtfe_ram.
package rtfe_pkg;

   localparam int RAND_W    = 60;
   localparam int LED_IDX_W = 5;
   localparam int LEVEL_W   = 8;
   localparam int PCT_W     = 7;
   localparam int DENS_W    = 6;
   localparam int PERIOD_W  = 16;
   localparam int STEP_W    = 7;
   localparam int TRY_W     = 4;
   localparam int MAX_TRIES = 10;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PEAK    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DENSITY = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PERIOD  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STEP    = 3'd4;

   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd40;
   localparam logic [STEP_W-1:0]   DEFAULT_STEP   = 7'd6;
   localparam logic [PCT_W-1:0]    RESET_PCT      = 7'd100;
   localparam logic [LEVEL_W-1:0]  RESET_PEAK     = 8'd255;
   localparam logic [PERIOD_W-1:0] TICK_MAX       = 16'hFFFF;

   // Effective configuration as seen by the frame engine.
   typedef struct packed {
      logic                enable;
      logic [LEVEL_W-1:0]  peak;
      logic [DENS_W-1:0]   density;
      logic [PERIOD_W-1:0] period;
      logic [STEP_W-1:0]   step;
   } cfg_type;

   // Per-item commands from the tick timer to the frame engine.
   typedef struct packed {
      logic start;
      logic restart;
   } ctl_type;

   // Peak level = pct * 255 / 100, truncated and saturated at 255.
   // The times-255 is a shift and subtract; the divide by 100 is a multiply
   // by ceil(2^19/100) = 5243, exact for every product below 2^15.
   function automatic logic [LEVEL_W-1:0] peak_from_percent(input logic [PCT_W-1:0] pct);
      logic [14:0] scaled;
      logic [27:0] prod;
      logic [8:0]  quo;
      scaled = {pct, 8'd0} - 15'(pct);
      prod   = 28'(scaled) * 28'd5243;
      quo    = prod[27:19];
      return (quo > 9'd255) ? 8'hFF : quo[7:0];
   endfunction

endpackage

@@ rtl/rtfe_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on rtfe_pkg for the payload widths.
interface rtfe_req_if;
   import rtfe_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [RAND_W-1:0] random_bits;
   modport source (output valid, mode, random_bits, input ready);
   modport sink   (input valid, mode, random_bits, output ready);
endinterface

interface rtfe_rsp_if;
   import rtfe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [LED_IDX_W-1:0] led_index;
   logic [LEVEL_W-1:0]   led_level;
   logic                 frame_last;
   modport source (output valid, led_index, led_level, frame_last, input ready);
   modport sink   (input valid, led_index, led_level, frame_last, output ready);
endinterface

@@ rtl/rtfe_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rtfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/rtfe_csr.sv @@
// Configuration registers behind an APB-style write/read port.
// Depends on rtfe_pkg; hands the effective settings on as one struct.
module rtfe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rtfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rtfe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rtfe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output rtfe_pkg::cfg_type                   cfg
);
   import rtfe_pkg::*;

   logic                 enable_ff,  enable_in;
   logic [PCT_W-1:0]     pct_ff,     pct_in;
   logic [LEVEL_W-1:0]   peak_ff,    peak_in;
   logic [DENS_W-1:0]    density_ff, density_in;
   logic [PERIOD_W-1:0]  period_ff,  period_in;
   logic [STEP_W-1:0]    step_ff,    step_in;
   logic                 write_en;
   logic [REG_IDX_W-1:0] reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign reg_sel  = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      enable_in  = enable_ff;
      pct_in     = pct_ff;
      peak_in    = peak_ff;
      density_in = density_ff;
      period_in  = period_ff;
      step_in    = step_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_ENABLE:  enable_in = pwdata[0];
            REG_PEAK: begin
               pct_in  = pwdata[PCT_W-1:0];
               peak_in = peak_from_percent(pwdata[PCT_W-1:0]);
            end
            REG_DENSITY: density_in = pwdata[DENS_W-1:0];
            REG_PERIOD:  period_in  = pwdata[PERIOD_W-1:0];
            REG_STEP:    step_in    = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         pct_ff     <= RESET_PCT;
         peak_ff    <= RESET_PEAK;
         density_ff <= '0;
         period_ff  <= DEFAULT_PERIOD;
         step_ff    <= DEFAULT_STEP;
      end else begin
         enable_ff  <= enable_in;
         pct_ff     <= pct_in;
         peak_ff    <= peak_in;
         density_ff <= density_in;
         period_ff  <= period_in;
         step_ff    <= step_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_ENABLE:  prdata = CSR_DATA_W'(enable_ff);
         REG_PEAK:    prdata = CSR_DATA_W'(pct_ff);
         REG_DENSITY: prdata = CSR_DATA_W'(density_ff);
         REG_PERIOD:  prdata = CSR_DATA_W'(period_ff);
         REG_STEP:    prdata = CSR_DATA_W'(step_ff);
         default:     prdata = '0;
      endcase
   end

   // A zero period or step stands for the default value.
   assign cfg.enable  = enable_ff;
   assign cfg.peak    = peak_ff;
   assign cfg.density = density_ff;
   assign cfg.period  = (period_ff == '0) ? DEFAULT_PERIOD : period_ff;
   assign cfg.step    = (step_ff == '0) ? DEFAULT_STEP : step_ff;
endmodule

@@ rtl/rtfe_frame.sv @@
// Frame engine: LED level/delta memory, update pass, spawn tries, result register.
// Depends on rtfe_pkg, rtfe_rsp_if, rtfe_ram and the assertion macro header.
`include "random_twinkle_fade_engine_assert.svh"

module rtfe_frame #(
   parameter int LEDS        = 32,
   parameter int SPAWN_TRIES = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rtfe_pkg::cfg_type           cfg,
   input  rtfe_pkg::ctl_type           ctl,
   input  logic [rtfe_pkg::RAND_W-1:0] rand_bits,
   output logic                        busy,
   rtfe_rsp_if.source                  rsp
);
   import rtfe_pkg::*;

   localparam int IDX_W   = $clog2(LEDS);
   localparam int CNT_W   = $clog2(LEDS + 1);
   localparam int CMP_W   = (CNT_W > DENS_W) ? CNT_W : DENS_W;
   localparam int ENTRY_W = 2 * LEVEL_W;
   localparam int TRIES   = (SPAWN_TRIES < MAX_TRIES) ? SPAWN_TRIES : MAX_TRIES;

   localparam logic [CNT_W-1:0] LED_CNT   = CNT_W'(LEDS);
   localparam logic [CNT_W-1:0] LAST_LED  = CNT_W'(LEDS - 1);
   localparam logic [TRY_W-1:0] TRY_LIMIT = TRY_W'(TRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_SPRD = 2'd2;
   localparam logic [1:0] ST_SPCK = 2'd3;

   logic [1:0]           state_ff,    state_in;
   logic [CNT_W-1:0]     rd_idx_ff,   rd_idx_in;
   logic                 ex_valid_ff, ex_valid_in;
   logic [IDX_W-1:0]     ex_idx_ff,   ex_idx_in;
   logic                 ex_last_ff,  ex_last_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [CMP_W-1:0]     active_ff,   active_in;
   logic [TRY_W-1:0]     try_ff,      try_in;
   logic [RAND_W-1:0]    rb_ff,       rb_in;
   logic [IDX_W-1:0]     sp_idx_ff,   sp_idx_in;
   logic [LEDS-1:0]      valid_ff,    valid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LED_IDX_W-1:0] rsp_index_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic                 rsp_last_ff;

   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]   ram_wdata, ram_q;

   logic                 out_free, ex_fire, issue, out_load;
   logic [LEVEL_W-1:0]   cur_level, new_level;
   logic [LEVEL_W-1:0]   cur_delta, new_delta;
   logic signed [9:0]    level_sum;
   logic [IDX_W-1:0]     spawn_idx;
   logic                 spawn_in_range, below_density;

   rtfe_ram #(.WIDTH(ENTRY_W), .DEPTH(LEDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   // An entry never written since the last restart reads as dark and idle.
   assign cur_level = rd_valid_ff ? ram_q[ENTRY_W-1:LEVEL_W] : '0;
   assign cur_delta = rd_valid_ff ? ram_q[LEVEL_W-1:0] : '0;

   assign level_sum = $signed({2'b00, cur_level}) + $signed({{2{cur_delta[7]}}, cur_delta});

   always_comb begin
      new_level = cur_level;
      new_delta = cur_delta;
      if (cur_delta != '0) begin
         if (level_sum >= $signed({2'b00, cfg.peak})) begin
            new_level = cfg.peak;
            new_delta = 8'd0 - {1'b0, cfg.step};
         end else if (level_sum <= 10'sd0) begin
            new_level = '0;
            new_delta = '0;
         end else begin
            new_level = level_sum[7:0];
         end
      end
   end

   assign out_free       = !rsp_valid_ff || rsp.ready;
   assign ex_fire        = ex_valid_ff && out_free;
   assign issue          = (state_ff == ST_UPD) && (rd_idx_ff < LED_CNT) &&
                           (!ex_valid_ff || out_free);
   assign spawn_idx      = rb_ff[IDX_W-1:0];
   assign spawn_in_range = CNT_W'(spawn_idx) < LED_CNT;
   assign below_density  = active_ff < CMP_W'(cfg.density);

   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      ex_valid_in = ex_valid_ff;
      ex_idx_in   = ex_idx_ff;
      ex_last_in  = ex_last_ff;
      rd_valid_in = rd_valid_ff;
      active_in   = active_ff;
      try_in      = try_ff;
      rb_in       = rb_ff;
      sp_idx_in   = sp_idx_ff;
      ram_re      = 1'b0;
      ram_raddr   = rd_idx_ff[IDX_W-1:0];
      ram_we      = 1'b0;
      ram_waddr   = ex_idx_ff;
      ram_wdata   = {new_level, new_delta};
      out_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in  = ST_UPD;
               rd_idx_in = '0;
               active_in = '0;
               try_in    = '0;
               rb_in     = rand_bits;
            end
         end
         ST_UPD: begin
            // Reads run one LED ahead of the write-back, so the two never
            // touch the same entry in one cycle.
            if (ex_fire) begin
               out_load    = 1'b1;
               ex_valid_in = 1'b0;
               if (cur_delta != '0) begin
                  ram_we    = 1'b1;
                  active_in = active_ff + 1'b1;
               end
               if (ex_last_ff) begin
                  state_in = ST_SPRD;
               end
            end
            if (issue) begin
               ram_re      = 1'b1;
               ex_valid_in = 1'b1;
               ex_idx_in   = rd_idx_ff[IDX_W-1:0];
               ex_last_in  = (rd_idx_ff == LAST_LED);
               rd_valid_in = valid_ff[rd_idx_ff[IDX_W-1:0]];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end
         end
         ST_SPRD: begin
            if ((try_ff < TRY_LIMIT) && below_density) begin
               try_in = try_ff + 1'b1;
               rb_in  = rb_ff >> IDX_W;
               if (spawn_in_range) begin
                  ram_re      = 1'b1;
                  ram_raddr   = spawn_idx;
                  rd_valid_in = valid_ff[spawn_idx];
                  sp_idx_in   = spawn_idx;
                  state_in    = ST_SPCK;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SPCK: begin
            if ((cur_delta == '0) && (cur_level == '0)) begin
               ram_we    = 1'b1;
               ram_waddr = sp_idx_ff;
               ram_wdata = {{LEVEL_W{1'b0}}, {1'b0, cfg.step}};
               active_in = active_ff + 1'b1;
            end
            state_in = ST_SPRD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.restart) begin
         valid_in = '0;
      end else if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         ex_valid_ff  <= 1'b0;
         rd_valid_ff  <= 1'b0;
         active_ff    <= '0;
         try_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         ex_valid_ff  <= ex_valid_in;
         rd_valid_ff  <= rd_valid_in;
         active_ff    <= active_in;
         try_ff       <= try_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_idx_ff  <= ex_idx_in;
      ex_last_ff <= ex_last_in;
      rb_ff      <= rb_in;
      sp_idx_ff  <= sp_idx_in;
      if (out_load) begin
         rsp_index_ff <= LED_IDX_W'(ex_idx_ff);
         rsp_level_ff <= new_level;
         rsp_last_ff  <= ex_last_ff;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.led_index  = rsp_index_ff;
   assign rsp.led_level  = rsp_level_ff;
   assign rsp.frame_last = rsp_last_ff;

   `RTFE_ASSERT_IMP(a_rw_distinct, clock, reset, ram_we && ram_re,
                    ram_waddr != ram_raddr, "read and write hit one entry in one cycle")
   `RTFE_ASSERT_IMP(a_cmd_when_idle, clock, reset, ctl.start || ctl.restart,
                    state_ff == ST_IDLE, "frame command arrived while a frame runs")
   `RTFE_ASSERT_IMP(a_ex_in_update, clock, reset, ex_valid_ff,
                    state_ff == ST_UPD, "read data pending outside the update pass")
   `RTFE_ASSERT_NXT(a_last_result, clock, reset, ex_fire && ex_last_ff,
                    rsp_valid_ff && rsp_last_ff && (state_ff == ST_SPRD),
                    "last LED of the pass did not close the frame")
endmodule

@@ rtl/random_twinkle_fade_engine.sv @@
// Top level of the random twinkle fade engine: tick timer and block wiring.
// Depends on rtfe_pkg, rtfe_if, rtfe_csr and rtfe_frame.
//
// Each input transfer is a millisecond tick or a restart; a restart clears
// every LED level and delta and the frame timer, and a tick that does not
// run a frame is also taken and yields nothing. While enabled, the first
// tick after a restart runs a frame, and after that one frame runs every
// frame_period_ms ticks. A frame walks the LED memory once, one LED per
// cycle while the result side takes results, because the level/delta RAM
// has one read port; each LED's final level leaves as one result transfer
// in ascending order, the last one flagged by frame_last. After the walk
// come up to min(SPAWN_TRIES, MAX_TRIES) tries to start dark LEDs rising;
// a try that names a valid LED reads it, then checks it and writes it back,
// an out-of-range slice is skipped, and the tries end early once the
// density is met. No new input transfer is accepted until the frame is
// done. The random index slices come from the random_bits field, try t
// using the log2(LEDS)-bit slice at bit t*log2(LEDS).
// Registers are written at byte address 4*i over the APB-style port:
// ambient_enable, peak_percent, density, frame_period_ms, fade_step.
module random_twinkle_fade_engine #(
   parameter int LEDS        = 32,
   parameter int SPAWN_TRIES = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   rtfe_req_if.sink                        req_ch,
   rtfe_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rtfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rtfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rtfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import rtfe_pkg::*;

   cfg_type             cfg;
   ctl_type             ctl;
   logic                busy;
   logic                accept;
   logic                frame_due;
   logic [PERIOD_W-1:0] ticks_sat;
   logic [PERIOD_W-1:0] ticks_ff, ticks_in;
   logic                pending_ff, pending_in;

   rtfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rtfe_frame #(.LEDS(LEDS), .SPAWN_TRIES(SPAWN_TRIES)) u_frame (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctl       (ctl),
      .rand_bits (req_ch.random_bits),
      .busy      (busy),
      .rsp       (rsp_ch)
   );

   // Inputs are taken whenever no frame is in progress, even while the last
   // result of the previous frame still waits in the output register.
   assign req_ch.ready = !busy;
   assign accept       = req_ch.valid && req_ch.ready;

   // Ticks are counted whether or not the pattern is enabled, and the count
   // saturates instead of wrapping.
   assign ticks_sat = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 1'b1;
   assign frame_due = cfg.enable && (pending_ff || (ticks_sat >= cfg.period));

   assign ctl.restart = accept && req_ch.mode;
   assign ctl.start   = accept && !req_ch.mode && frame_due;

   always_comb begin
      ticks_in   = ticks_ff;
      pending_in = pending_ff;
      if (ctl.restart) begin
         ticks_in   = '0;
         pending_in = 1'b1;
      end else if (accept) begin
         if (frame_due) begin
            ticks_in   = '0;
            pending_in = 1'b0;
         end else begin
            ticks_in = ticks_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff   <= '0;
         pending_ff <= 1'b1;
      end else begin
         ticks_ff   <= ticks_in;
         pending_ff <= pending_in;
      end
   end
endmodule
